### rtl/core/embcm_pkg.sv
// Shared request codes, result codes and fixed-point constants of the embedding store.
package embcm_pkg;

    localparam logic [1:0] REQ_ENROLL = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_PROBE  = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic signed [15:0] SCORE_NONE = 16'sh8000;

    localparam int Q_BITS   = 15;
    localparam int Q_SHIFT  = 28;
    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 32;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [15:0] score_t;

endpackage

### rtl/core/embcm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module embcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/embedding_store_cosine_match.sv
// Embedding vector store with a cosine-similarity nearest-match search.
//
// Channel  Direction  Handshake            Payload
// s        in         s_tvalid/s_tready    s_tuser request type, s_tdata element fields
// m        out        m_tvalid/m_tready    m_tdata result fields
// cfg      in         cfg_wr_en            cfg_wr_data match threshold
//
// Every request except the last element of a probe is handled without leaving the idle state.
// The last probe element starts a search that runs, for each active slot below the
// count, the element products through the one shared multiplier, then the two wide
// products in the shift-add unit and a bit-by-bit square root.
// A result waiting in the output register blocks every request until the register
// is free. Reset clears the slot flags and the threshold; vector memories are not
// cleared.
module embedding_store_cosine_match #(
    parameter int RECORDS = 16,
    parameter int EMB_DIM = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // slot[3:0], elem_index[10:4], elem_value[26:11]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[0], slot_index[4:1], score[20:5],
                                   // matched[21], record_count[26:22]
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import embcm_pkg::*;

    localparam int SW   = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CW   = $clog2(RECORDS + 1);
    localparam int DW   = (EMB_DIM > 1) ? $clog2(EMB_DIM) : 1;
    localparam int AW   = (RECORDS * EMB_DIM > 1) ? $clog2(RECORDS * EMB_DIM) : 1;
    localparam int KW   = $clog2(EMB_DIM + 1);
    localparam int DOTW = PROD_W + KW;
    localparam int MW   = DOTW - 1;
    localparam int PW   = 2 * MW;
    localparam int RW   = PW + Q_SHIFT + 4;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SLOT = 4'd1;
    localparam logic [3:0] S_ADDR = 4'd2;
    localparam logic [3:0] S_M0   = 4'd3;
    localparam logic [3:0] S_M1   = 4'd4;
    localparam logic [3:0] S_M2   = 4'd5;
    localparam logic [3:0] S_M3   = 4'd6;
    localparam logic [3:0] S_NORM = 4'd7;
    localparam logic [3:0] S_MULP = 4'd8;
    localparam logic [3:0] S_MULR = 4'd9;
    localparam logic [3:0] S_SQRT = 4'd10;
    localparam logic [3:0] S_CMP  = 4'd11;
    localparam logic [3:0] S_NEXT = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    function automatic logic [CW-1:0] high_count(input logic [RECORDS-1:0] act);
        logic [CW-1:0] c;
        c = '0;
        for (int n = 0; n < RECORDS; n++)
        begin
            if (act[n])
            begin
                c = CW'(n + 1);
            end
        end
        return c;
    endfunction

    function automatic logic [SW:0] first_free(input logic [RECORDS-1:0] act);
        logic [SW:0] r;
        r = '0;
        for (int n = RECORDS - 1; n >= 0; n--)
        begin
            if (!act[n])
            begin
                r = {1'b1, SW'(n)};
            end
        end
        return r;
    endfunction

    // Control registers.
    logic [3:0]         state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [RECORDS-1:0] active_reg, active_next;
    logic [SW-1:0]      tgt_reg, tgt_next;
    logic               drop_reg, drop_next;
    score_t             thr_reg;

    // Payload registers.
    logic [31:0]        out_data_reg, out_data_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [DW-1:0]      k_reg, k_next;
    logic signed [DOTW-1:0] dot_reg, dot_next;
    logic [MW-1:0]      na_reg, na_next, nb_reg, nb_next;
    logic signed [PROD_W-1:0] mul_reg;
    logic [PW-1:0]      ma_reg, ma_next, acc_reg, acc_next, p_reg, p_next;
    logic [MW-1:0]      mb_reg, mb_next;
    logic [RW-1:0]      r_reg, r_next, pb_reg, pb_next, tb_reg, tb_next, sq_reg, sq_next;
    logic [Q_BITS-1:0]  q_reg, q_next;
    logic [3:0]         b_reg, b_next;
    score_t             score_reg, score_next, best_reg, best_next;
    logic [SW-1:0]      bi_reg, bi_next;

    // Combinational helpers.
    logic        accept;
    logic [3:0]  f_slot;
    logic [6:0]  f_idx;
    elem_t       f_val;
    logic        idx_ok, idx_last;
    logic [SW:0] ff;
    logic [CW-1:0] hwc;
    logic [MW-1:0] dot_mag;
    logic [RW-1:0] cand;
    elem_t       op_x, op_y;
    logic        out_free;

    logic          st_we, pb_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [DW-1:0] pb_waddr;
    logic [ELEM_W-1:0] st_rdata, pb_rdata;

    assign f_slot   = s_tdata[3:0];
    assign f_idx    = s_tdata[10:4];
    assign f_val    = s_tdata[26:11];
    assign idx_ok   = 32'(f_idx) < EMB_DIM;
    assign idx_last = 32'(f_idx) == EMB_DIM - 1;
    assign ff       = first_free(active_reg);
    assign hwc      = high_count(active_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign dot_mag  = dot_reg[DOTW-1] ? MW'(-dot_reg) : MW'(dot_reg);
    assign cand     = sq_reg + tb_reg + pb_reg;

    assign st_raddr = AW'(i_reg[SW-1:0]) * AW'(EMB_DIM) + AW'(k_reg);

    embcm_ram #(.WIDTH(ELEM_W), .DEPTH(RECORDS * EMB_DIM)) u_store (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (f_val),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    embcm_ram #(.WIDTH(ELEM_W), .DEPTH(EMB_DIM)) u_probe (
        .clk     (clk),
        .wr_en   (pb_we),
        .wr_addr (pb_waddr),
        .wr_data (f_val),
        .rd_addr (k_reg),
        .rd_data (pb_rdata)
    );

    always_comb
    begin
        op_x = pb_rdata;
        op_y = st_rdata;
        case (state_reg)
            S_M1:
            begin
                op_x = pb_rdata;
                op_y = pb_rdata;
            end
            S_M2:
            begin
                op_x = st_rdata;
                op_y = st_rdata;
            end
            default:
            begin
                op_x = pb_rdata;
                op_y = st_rdata;
            end
        endcase
    end

    always_comb
    begin
        logic [RECORDS-1:0] act_w;
        act_w = active_reg;

        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        active_next    = active_reg;
        tgt_next       = tgt_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        dot_next       = dot_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        acc_next       = acc_reg;
        p_next         = p_reg;
        r_next         = r_reg;
        pb_next        = pb_reg;
        tb_next        = tb_reg;
        sq_next        = sq_reg;
        q_next         = q_reg;
        b_next         = b_reg;
        score_next     = score_reg;
        best_next      = best_reg;
        bi_next        = bi_reg;
        st_we          = 1'b0;
        st_waddr       = AW'(tgt_reg) * AW'(EMB_DIM) + AW'(f_idx);
        pb_we          = 1'b0;
        pb_waddr       = DW'(f_idx);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        REQ_ENROLL:
                        begin
                            if (idx_ok)
                            begin
                                if (f_idx == 7'd0)
                                begin
                                    drop_next = !ff[SW];
                                    if (ff[SW])
                                    begin
                                        tgt_next = ff[SW-1:0];
                                    end
                                end
                                st_we    = !drop_next;
                                st_waddr = AW'(tgt_next) * AW'(EMB_DIM) + AW'(f_idx);
                                if (idx_last)
                                begin
                                    if (drop_next)
                                    begin
                                        out_data_next = {5'd0, 5'(hwc), 1'b0, 16'd0,
                                                         4'd0, STATUS_FULL};
                                    end
                                    else
                                    begin
                                        act_w[tgt_next] = 1'b1;
                                        active_next     = act_w;
                                        out_data_next = {5'd0, 5'(high_count(act_w)), 1'b0,
                                                         16'd0, 4'(tgt_next), STATUS_DONE};
                                    end
                                    out_valid_next = 1'b1;
                                end
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (32'(f_slot) < RECORDS)
                            begin
                                act_w[SW'(f_slot)] = 1'b0;
                                active_next        = act_w;
                            end
                            out_data_next  = {5'd0, 5'(high_count(act_w)), 1'b0, 16'd0,
                                              f_slot, STATUS_DONE};
                            out_valid_next = 1'b1;
                        end
                        REQ_PROBE:
                        begin
                            if (idx_ok)
                            begin
                                pb_we = 1'b1;
                                if (idx_last)
                                begin
                                    i_next    = '0;
                                    best_next = SCORE_NONE;
                                    bi_next   = '0;
                                    state_next = (hwc == '0) ? S_DONE : S_SLOT;
                                end
                            end
                        end
                        default:
                        begin
                            active_next    = '0;
                            out_data_next  = {5'd0, 5'd0, 1'b0, 16'd0, 4'd0, STATUS_DONE};
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SLOT:
            begin
                if (active_reg[i_reg[SW-1:0]])
                begin
                    k_next     = '0;
                    dot_next   = '0;
                    na_next    = '0;
                    nb_next    = '0;
                    state_next = S_ADDR;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_ADDR:
            begin
                state_next = S_M0;
            end
            S_M0:
            begin
                state_next = S_M1;
            end
            S_M1:
            begin
                dot_next   = dot_reg + DOTW'(mul_reg);
                state_next = S_M2;
            end
            S_M2:
            begin
                na_next    = na_reg + MW'($unsigned(mul_reg));
                state_next = S_M3;
            end
            S_M3:
            begin
                nb_next = nb_reg + MW'($unsigned(mul_reg));
                if (32'(k_reg) == EMB_DIM - 1)
                begin
                    state_next = S_NORM;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_ADDR;
                end
            end
            S_NORM:
            begin
                if (na_reg == '0 || nb_reg == '0)
                begin
                    score_next = '0;
                    state_next = S_CMP;
                end
                else
                begin
                    ma_next    = PW'(na_reg);
                    mb_next    = nb_reg;
                    acc_next   = '0;
                    state_next = S_MULP;
                end
            end
            S_MULP:
            begin
                if (mb_reg == '0)
                begin
                    p_next     = acc_reg;
                    ma_next    = PW'(dot_mag);
                    mb_next    = dot_mag;
                    acc_next   = '0;
                    state_next = S_MULR;
                end
                else
                begin
                    if (mb_reg[0])
                    begin
                        acc_next = acc_reg + ma_reg;
                    end
                    ma_next = ma_reg << 1;
                    mb_next = mb_reg >> 1;
                end
            end
            S_MULR:
            begin
                if (mb_reg == '0)
                begin
                    r_next     = RW'(acc_reg) << Q_SHIFT;
                    pb_next    = RW'(p_reg) << Q_SHIFT;
                    tb_next    = '0;
                    sq_next    = '0;
                    q_next     = '0;
                    b_next     = 4'(Q_BITS - 1);
                    state_next = S_SQRT;
                end
                else
                begin
                    if (mb_reg[0])
                    begin
                        acc_next = acc_reg + ma_reg;
                    end
                    ma_next = ma_reg << 1;
                    mb_next = mb_reg >> 1;
                end
            end
            S_SQRT:
            begin
                if (cand <= r_reg)
                begin
                    sq_next = cand;
                    q_next  = q_reg | (Q_BITS'(1) << b_reg);
                    tb_next = (tb_reg >> 1) + pb_reg;
                end
                else
                begin
                    tb_next = tb_reg >> 1;
                end
                pb_next = pb_reg >> 2;
                if (b_reg == 4'd0)
                begin
                    score_next = dot_reg[DOTW-1] ? -$signed(16'(q_next))
                                                 : $signed(16'(q_next));
                    state_next = S_CMP;
                end
                else
                begin
                    b_next = b_reg - 1'b1;
                end
            end
            S_CMP:
            begin
                if (score_reg > best_reg)
                begin
                    best_next = score_reg;
                    bi_next   = i_reg[SW-1:0];
                end
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if ((CW+1)'(i_reg) + 1'b1 >= (CW+1)'(hwc))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SLOT;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = {5'd0, 5'(hwc), best_reg >= thr_reg, best_reg,
                                      4'(bi_reg), STATUS_DONE};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            active_reg    <= '0;
            tgt_reg       <= '0;
            drop_reg      <= 1'b0;
            thr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            tgt_reg       <= tgt_next;
            drop_reg      <= drop_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        dot_reg      <= dot_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        mul_reg      <= op_x * op_y;
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        acc_reg      <= acc_next;
        p_reg        <= p_next;
        r_reg        <= r_next;
        pb_reg       <= pb_next;
        tb_reg       <= tb_next;
        sq_reg       <= sq_next;
        q_reg        <= q_next;
        b_reg        <= b_next;
        score_reg    <= score_next;
        best_reg     <= best_next;
        bi_reg       <= bi_next;
    end

endmodule
